// ----- hdl/icmprw_pkg.sv -----
`timescale 1ns / 1ps
package icmprw_pkg;

    // words of one frame that may wait for the verdict
    localparam int HEADER_WORDS = 16;
    localparam int CNT_W        = $clog2(HEADER_WORDS);
    localparam int AVAIL_W      = CNT_W + 4;

    // word queue between front and back, room for the waiting words of two frames
    localparam int WQ_DEPTH = 2 * HEADER_WORDS;
    localparam int WQ_PTR_W = $clog2(WQ_DEPTH);
    localparam int WQ_CNT_W = $clog2(WQ_DEPTH + 1);

    // verdict queue, one entry per frame
    localparam int VQ_DEPTH = 2;
    localparam int VQ_PTR_W = $clog2(VQ_DEPTH);
    localparam int VQ_CNT_W = $clog2(VQ_DEPTH + 1);

    localparam logic [7:0] PROTO_ICMP        = 8'd1;
    localparam logic [7:0] ICMP_ECHO_REQUEST = 8'd8;
    localparam logic [7:0] ICMP_ECHO_REPLY   = 8'd0;
    localparam logic [7:0] TTL_RESET         = 8'd125;
    localparam logic [15:0] ICMP_TYPE_OLD    = 16'h0800;
    localparam logic [15:0] ICMP_TYPE_NEW    = 16'h0000;

    localparam int MIN_IP_BYTES   = 34;
    localparam int ICMP_HDR_BYTES = 8;
    localparam int MAC_BYTES      = 6;
    localparam int IP_SRC_POS     = 26;
    localparam int IP_DST_POS     = 30;
    localparam int IP_END_POS     = 34;
    localparam int TTL_POS        = 22;
    localparam int IP_CSUM_POS    = 24;
    localparam int IHL_POS        = 14;

    typedef logic [11:0][7:0] mac_t;
    typedef logic [7:0][7:0]  ip_t;

    typedef struct packed {
        logic [63:0] word;
        logic [3:0]  nbytes;
        logic        last;
    } qword_t;

    typedef struct packed {
        logic        reply;
        mac_t        mac;
        ip_t         ip;
        logic [7:0]  ttl;
        logic [15:0] ip_csum;
        logic [6:0]  icmp_off;
        logic [15:0] icmp_csum;
    } verdict_t;

    function automatic logic [7:0] word_byte(logic [63:0] w, logic [2:0] k);
        return w[8 * (7 - int'(k)) +: 8];
    endfunction

    // one's complement add with end-around carry
    function automatic logic [15:0] ones_add(logic [15:0] a, logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        s = {1'b0, s[15:0]} + {16'd0, s[16]};
        s = {1'b0, s[15:0]} + {16'd0, s[16]};
        return s[15:0];
    endfunction

    // incremental checksum: HC' = ~(~HC + ~m + m')
    function automatic logic [15:0] csum_update(logic [15:0] hc, logic [15:0] oldv,
                                                logic [15:0] newv);
        return ~ones_add(ones_add(~hc, ~oldv), newv);
    endfunction

    // mac swap, ip swap, ttl and ip checksum, applied in that order
    function automatic logic [7:0] patch_byte(logic [6:0] p, logic [7:0] orig, mac_t mac,
                                              ip_t ip, logic [7:0] ttl, logic [15:0] ipcs);
        logic [7:0] r;
        logic [6:0] mi_dst;
        logic [6:0] mi_src;
        logic [6:0] ii_src;
        logic [6:0] ii_dst;
        r      = orig;
        mi_dst = p + 7'(MAC_BYTES);
        mi_src = p - 7'(MAC_BYTES);
        ii_src = p - 7'(IP_SRC_POS) + 7'(IP_DST_POS - IP_SRC_POS);
        ii_dst = p - 7'(IP_DST_POS);
        if (p < 7'(MAC_BYTES))
            r = mac[mi_dst[3:0]];
        else if (p < 7'(2 * MAC_BYTES))
            r = mac[mi_src[3:0]];
        if (p >= 7'(IP_SRC_POS) && p < 7'(IP_DST_POS))
            r = ip[ii_src[2:0]];
        else if (p >= 7'(IP_DST_POS) && p < 7'(IP_END_POS))
            r = ip[ii_dst[2:0]];
        if (p == 7'(TTL_POS))
            r = ttl;
        else if (p == 7'(IP_CSUM_POS))
            r = ipcs[15:8];
        else if (p == 7'(IP_CSUM_POS + 1))
            r = ipcs[7:0];
        return r;
    endfunction

endpackage

// ----- hdl/icmp_echo_reply_rewriter_core.sv -----
`timescale 1ns / 1ps
// ICMP echo responder on 64-bit frame beats. Takes up to one beat per cycle and gives
// up to one result beat per cycle; every input beat yields exactly one output beat, in
// order. The leading beats of a frame wait in a 32-entry word queue until the front has
// classified the frame (at the latest on beat 11, or on the last beat of a short frame),
// so a frame's first beat leaves only after its deciding beat went in; every beat passes
// through the word queue memory, its head register and the output register. The front
// stalls (full) only when the word queue or the two-entry verdict queue fills up;
// back-to-back single-beat frames hit the verdict queue limit. Echo requests leave with
// send_back high, MACs and IPv4 addresses swapped, TTL set to reply_ttl, type 0 and both
// checksums incrementally updated; everything else passes unchanged with send_back low.
// Write reply_ttl only while the block is idle.
module icmp_echo_reply_rewriter_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [63:0] frame_word,
    input  logic [3:0]  word_bytes,
    input  logic        frame_end,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] out_word,
    output logic [3:0]  out_bytes,
    output logic        out_end,
    output logic        send_back,
    input  logic        reply_ttl_we,
    input  logic [7:0]  reply_ttl_wdata
);
    import icmprw_pkg::*;

    logic     wq_push;
    qword_t   wq_wr_data;
    logic     wq_full;
    logic     wq_valid;
    qword_t   wq_rd_data;
    logic     wq_pop;
    logic     vq_push;
    verdict_t vq_entry;
    logic     vq_full;

    icmprw_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .frame_word      (frame_word),
        .word_bytes      (word_bytes),
        .frame_end       (frame_end),
        .reply_ttl_we    (reply_ttl_we),
        .reply_ttl_wdata (reply_ttl_wdata),
        .wq_push         (wq_push),
        .wq_data         (wq_wr_data),
        .wq_full         (wq_full),
        .vq_push         (vq_push),
        .vq_entry        (vq_entry),
        .vq_full         (vq_full)
    );

    icmprw_word_queue u_word_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wq_push),
        .wr_data  (wq_wr_data),
        .full     (wq_full),
        .rd_valid (wq_valid),
        .rd_data  (wq_rd_data),
        .rd_pop   (wq_pop)
    );

    icmprw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .wq_valid  (wq_valid),
        .wq_data   (wq_rd_data),
        .wq_pop    (wq_pop),
        .vq_push   (vq_push),
        .vq_entry  (vq_entry),
        .vq_full   (vq_full),
        .empty     (empty),
        .pop       (pop),
        .out_word  (out_word),
        .out_bytes (out_bytes),
        .out_end   (out_end),
        .send_back (send_back)
    );

endmodule

// ----- hdl/icmprw_word_queue.sv -----
`timescale 1ns / 1ps
module icmprw_word_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  icmprw_pkg::qword_t wr_data,
    output logic               full,
    output logic               rd_valid,
    output icmprw_pkg::qword_t rd_data,
    input  logic               rd_pop
);
    import icmprw_pkg::*;

    qword_t              mem [WQ_DEPTH];
    qword_t              head_reg;
    logic                head_valid_reg;
    logic [WQ_PTR_W-1:0] wr_ptr_reg;
    logic [WQ_PTR_W-1:0] rd_ptr_reg;
    logic [WQ_CNT_W-1:0] cnt_reg;
    logic                fetch;

    assign full     = cnt_reg == WQ_CNT_W'(WQ_DEPTH);
    // head register doubles as the registered read port
    assign fetch    = (cnt_reg != '0) && (!head_valid_reg || rd_pop);
    assign rd_valid = head_valid_reg;
    assign rd_data  = head_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= wr_data;
        if (fetch)
            head_reg <= mem[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            cnt_reg        <= '0;
            head_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= (wr_ptr_reg == WQ_PTR_W'(WQ_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
            if (fetch)
                rd_ptr_reg <= (rd_ptr_reg == WQ_PTR_W'(WQ_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
            if (wr_en && !fetch)
                cnt_reg <= cnt_reg + 1'b1;
            else if (!wr_en && fetch)
                cnt_reg <= cnt_reg - 1'b1;
            if (fetch)
                head_valid_reg <= 1'b1;
            else if (rd_pop)
                head_valid_reg <= 1'b0;
        end
    end

endmodule

// ----- hdl/icmprw_front.sv -----
`timescale 1ns / 1ps
module icmprw_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [63:0]          frame_word,
    input  logic [3:0]           word_bytes,
    input  logic                 frame_end,
    input  logic                 reply_ttl_we,
    input  logic [7:0]           reply_ttl_wdata,
    output logic                 wq_push,
    output icmprw_pkg::qword_t   wq_data,
    input  logic                 wq_full,
    output logic                 vq_push,
    output icmprw_pkg::verdict_t vq_entry,
    input  logic                 vq_full
);
    import icmprw_pkg::*;

    logic               accept;
    logic               decided_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [7:0]         reply_ttl_reg;

    mac_t               mac_reg;
    ip_t                ip_reg;
    logic [3:0]         ihl_reg;
    logic [7:0]         ttl_old_reg;
    logic [7:0]         proto_reg;
    logic [7:0]         type_reg;
    logic [7:0]         c2_reg;
    logic [7:0]         c3_reg;
    logic [15:0]        ip_csum_reg;

    logic [3:0]         last_bytes;
    logic [AVAIL_W-1:0] avail;
    logic [7:0]         ihl_byte;
    logic [3:0]         ihl_eff;
    logic [6:0]         off;
    logic [6:0]         off2;
    logic [6:0]         off3;
    logic               at_off;
    logic               at_off2;
    logic               at_off3;
    logic [7:0]         proto_eff;
    logic [7:0]         type_eff;
    logic [7:0]         c2_eff;
    logic [7:0]         c3_eff;
    ip_t                ip_eff;
    logic [15:0]        icmp_hc;
    logic               stop;
    logic               decide;
    logic               reply;

    assign full    = wq_full | vq_full;
    assign accept  = push & ~full;
    assign wq_push = accept;
    assign vq_push = accept & ~decided_reg & decide;

    assign last_bytes = frame_end ? ((word_bytes > 4'd8) ? 4'd8 : word_bytes) : 4'd8;
    assign avail      = AVAIL_W'({cnt_reg, 3'b000}) + AVAIL_W'(last_bytes);
    assign wq_data    = '{word: frame_word, nbytes: last_bytes, last: frame_end};

    // header fields may sit in the word being accepted right now
    assign ihl_byte  = word_byte(frame_word, 3'(IHL_POS % 8));
    assign ihl_eff   = (cnt_reg == CNT_W'(IHL_POS / 8)) ? ihl_byte[3:0] : ihl_reg;
    assign off       = 7'(IHL_POS) + 7'({ihl_eff, 2'b00});
    assign off2      = off + 7'd2;
    assign off3      = off + 7'd3;
    assign at_off    = cnt_reg == CNT_W'(off[6:3]);
    assign at_off2   = cnt_reg == CNT_W'(off2[6:3]);
    assign at_off3   = cnt_reg == CNT_W'(off3[6:3]);
    assign proto_eff = (cnt_reg == CNT_W'((TTL_POS + 1) / 8)) ?
                       word_byte(frame_word, 3'((TTL_POS + 1) % 8)) : proto_reg;
    assign type_eff  = at_off  ? word_byte(frame_word, off[2:0])  : type_reg;
    assign c2_eff    = at_off2 ? word_byte(frame_word, off2[2:0]) : c2_reg;
    assign c3_eff    = at_off3 ? word_byte(frame_word, off3[2:0]) : c3_reg;

    always_comb
    begin
        ip_eff = ip_reg;
        if (cnt_reg == CNT_W'(IP_END_POS / 8))
        begin
            ip_eff[6] = word_byte(frame_word, 3'd0);
            ip_eff[7] = word_byte(frame_word, 3'd1);
        end
    end

    // icmp checksum field as it reads after the ip-level edits
    assign icmp_hc = {patch_byte(off2, c2_eff, mac_reg, ip_eff, reply_ttl_reg, ip_csum_reg),
                      patch_byte(off3, c3_eff, mac_reg, ip_eff, reply_ttl_reg, ip_csum_reg)};

    assign stop = frame_end || (cnt_reg == CNT_W'(HEADER_WORDS - 1));

    always_comb
    begin
        decide = 1'b1;
        reply  = 1'b0;
        if (avail < AVAIL_W'(MIN_IP_BYTES))
            decide = stop;
        else if (proto_eff != PROTO_ICMP)
            decide = 1'b1;
        else if (avail < AVAIL_W'(off) + AVAIL_W'(ICMP_HDR_BYTES))
            decide = stop;
        else
            reply = type_eff == ICMP_ECHO_REQUEST;
    end

    always_comb
    begin
        vq_entry.reply     = reply;
        vq_entry.mac       = mac_reg;
        vq_entry.ip        = ip_eff;
        vq_entry.ttl       = reply_ttl_reg;
        vq_entry.ip_csum   = ip_csum_reg;
        vq_entry.icmp_off  = off;
        vq_entry.icmp_csum = csum_update(icmp_hc, ICMP_TYPE_OLD, ICMP_TYPE_NEW);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decided_reg   <= 1'b0;
            cnt_reg       <= '0;
            reply_ttl_reg <= TTL_RESET;
        end
        else
        begin
            if (reply_ttl_we)
                reply_ttl_reg <= reply_ttl_wdata;
            if (accept)
            begin
                if (decided_reg)
                begin
                    if (frame_end)
                        decided_reg <= 1'b0;
                end
                else if (decide)
                begin
                    decided_reg <= !frame_end;
                    cnt_reg     <= '0;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    // header bytes picked off as their words go by
    always_ff @(posedge clk)
    begin
        if (accept && !decided_reg)
        begin
            if (cnt_reg == CNT_W'(0))
                for (int k = 0; k < 8; k++)
                    mac_reg[k] <= word_byte(frame_word, 3'(k));
            if (cnt_reg == CNT_W'(1))
            begin
                for (int k = 0; k < 4; k++)
                    mac_reg[8 + k] <= word_byte(frame_word, 3'(k));
                ihl_reg <= ihl_byte[3:0];
            end
            if (cnt_reg == CNT_W'(2))
            begin
                ttl_old_reg <= word_byte(frame_word, 3'(TTL_POS % 8));
                proto_reg   <= word_byte(frame_word, 3'((TTL_POS + 1) % 8));
            end
            if (cnt_reg == CNT_W'(3))
            begin
                for (int k = 2; k < 8; k++)
                    ip_reg[k - 2] <= word_byte(frame_word, 3'(k));
                ip_csum_reg <= csum_update({word_byte(frame_word, 3'd0),
                                            word_byte(frame_word, 3'd1)},
                                           {ttl_old_reg, 8'h00}, {reply_ttl_reg, 8'h00});
            end
            if (cnt_reg == CNT_W'(4))
            begin
                ip_reg[6] <= word_byte(frame_word, 3'd0);
                ip_reg[7] <= word_byte(frame_word, 3'd1);
            end
            if (at_off)
                type_reg <= word_byte(frame_word, off[2:0]);
            if (at_off2)
                c2_reg <= word_byte(frame_word, off2[2:0]);
            if (at_off3)
                c3_reg <= word_byte(frame_word, off3[2:0]);
        end
    end

    a_vq_room: assert property (@(posedge clk) disable iff (!rst_n)
        vq_push |-> !vq_full)
        else $error("verdict pushed into a full verdict queue");

    a_decided_after_midframe: assert property (@(posedge clk) disable iff (!rst_n)
        vq_push && !frame_end |=> decided_reg)
        else $error("frame decided mid-way but later words not passed");

    a_reply_needs_header: assert property (@(posedge clk) disable iff (!rst_n)
        vq_push && vq_entry.reply |-> cnt_reg >= CNT_W'(4))
        else $error("reply verdict before the ip header was complete");

endmodule

// ----- hdl/icmprw_back.sv -----
`timescale 1ns / 1ps
module icmprw_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wq_valid,
    input  icmprw_pkg::qword_t   wq_data,
    output logic                 wq_pop,
    input  logic                 vq_push,
    input  icmprw_pkg::verdict_t vq_entry,
    output logic                 vq_full,
    output logic                 empty,
    input  logic                 pop,
    output logic [63:0]          out_word,
    output logic [3:0]           out_bytes,
    output logic                 out_end,
    output logic                 send_back
);
    import icmprw_pkg::*;

    verdict_t            vq_mem [VQ_DEPTH];
    logic [VQ_PTR_W-1:0] vq_wr_ptr_reg;
    logic [VQ_PTR_W-1:0] vq_rd_ptr_reg;
    logic [VQ_CNT_W-1:0] vq_cnt_reg;
    verdict_t            head;
    logic                vq_pop;

    logic [3:0]          wcnt_reg;
    logic                out_valid_reg;
    logic [63:0]         out_word_reg;
    logic [3:0]          out_bytes_reg;
    logic                out_end_reg;
    logic                send_back_reg;
    logic                load;
    logic [63:0]         patched;
    logic [6:0]          pos [8];
    logic [7:0]          lane [8];

    assign head    = vq_mem[vq_rd_ptr_reg];
    assign vq_full = vq_cnt_reg == VQ_CNT_W'(VQ_DEPTH);
    // a word leaves only once its frame has a verdict
    assign load    = wq_valid && (vq_cnt_reg != '0) && (!out_valid_reg || pop);
    assign wq_pop  = load;
    assign vq_pop  = load && wq_data.last;

    assign empty     = !out_valid_reg;
    assign out_word  = out_word_reg;
    assign out_bytes = out_bytes_reg;
    assign out_end   = out_end_reg;
    assign send_back = send_back_reg;

    always_comb
    begin
        patched = wq_data.word;
        for (int k = 0; k < 8; k++)
        begin
            pos[k]  = {wcnt_reg, 3'(k)};
            lane[k] = patch_byte(pos[k], word_byte(wq_data.word, 3'(k)), head.mac, head.ip,
                                 head.ttl, head.ip_csum);
            if (pos[k] == head.icmp_off)
                lane[k] = ICMP_ECHO_REPLY;
            else if (pos[k] == head.icmp_off + 7'd2)
                lane[k] = head.icmp_csum[15:8];
            else if (pos[k] == head.icmp_off + 7'd3)
                lane[k] = head.icmp_csum[7:0];
            if (head.reply)
                patched[8 * (7 - k) +: 8] = lane[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (vq_push)
            vq_mem[vq_wr_ptr_reg] <= vq_entry;
        if (load)
        begin
            out_word_reg  <= patched;
            out_bytes_reg <= wq_data.nbytes;
            out_end_reg   <= wq_data.last;
            send_back_reg <= head.reply;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vq_wr_ptr_reg <= '0;
            vq_rd_ptr_reg <= '0;
            vq_cnt_reg    <= '0;
            wcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (vq_push)
                vq_wr_ptr_reg <= (vq_wr_ptr_reg == VQ_PTR_W'(VQ_DEPTH - 1)) ? '0
                                                                             : vq_wr_ptr_reg + 1'b1;
            if (vq_pop)
                vq_rd_ptr_reg <= (vq_rd_ptr_reg == VQ_PTR_W'(VQ_DEPTH - 1)) ? '0
                                                                             : vq_rd_ptr_reg + 1'b1;
            if (vq_push && !vq_pop)
                vq_cnt_reg <= vq_cnt_reg + 1'b1;
            else if (!vq_push && vq_pop)
                vq_cnt_reg <= vq_cnt_reg - 1'b1;
            if (load)
            begin
                out_valid_reg <= 1'b1;
                // word index saturates well past the last edited byte
                if (wq_data.last)
                    wcnt_reg <= '0;
                else if (wcnt_reg != 4'hF)
                    wcnt_reg <= wcnt_reg + 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_midframe_has_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        wcnt_reg != '0 |-> vq_cnt_reg != '0)
        else $error("frame in progress lost its verdict");

    a_vq_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vq_cnt_reg <= VQ_CNT_W'(VQ_DEPTH))
        else $error("verdict queue count out of range");

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        load && wq_data.last |=> wcnt_reg == '0)
        else $error("word index not cleared at end of frame");

endmodule

// ----- test/icmp_echo_checker.sv -----
`timescale 1ns / 1ps
module icmp_echo_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [63:0] frame_word,
    input  logic [3:0]  word_bytes,
    input  logic        frame_end,
    input  logic        empty,
    input  logic        pop,
    input  logic [63:0] out_word,
    input  logic [3:0]  out_bytes,
    input  logic        out_end,
    input  logic        send_back,
    input  logic        reply_ttl_we,
    input  logic [7:0]  reply_ttl_wdata,
    output int          fail_count,
    output int          pending
);
    import icmprw_pkg::*;

    localparam int PROTO_POS = 23;

    typedef struct packed {
        logic [63:0] word;
        logic [3:0]  nbytes;
        logic        last;
        logic        reply;
    } beat_t;

    beat_t       reply_beats[$];
    beat_t       got;
    beat_t       want;
    logic [63:0] held[HEADER_WORDS];
    int unsigned n_held;
    bit          decided;
    bit          is_reply;
    logic [7:0]  ttl_reg;
    int          fails;

    function automatic logic [15:0] ones_fold(logic [31:0] x);
        x = {16'd0, x[15:0]} + {16'd0, x[31:16]};
        x = {16'd0, x[15:0]} + {16'd0, x[31:16]};
        return x[15:0];
    endfunction

    // ~(~hc + ~old + new) in one's complement
    function automatic logic [15:0] incr_csum(logic [15:0] hc, logic [15:0] oldv,
                                              logic [15:0] newv);
        logic [15:0] c;
        c = ones_fold({16'd0, ~hc} + {16'd0, ~oldv});
        c = ones_fold({16'd0, c} + {16'd0, newv});
        return ~c;
    endfunction

    function automatic logic [7:0] held_byte(int unsigned pos);
        return held[(pos >> 3) % HEADER_WORDS][8 * (7 - (pos % 8)) +: 8];
    endfunction

    // edits go in order so that overlapping fields behave as on the wire
    function automatic void make_reply(int unsigned n);
        logic [7:0]  b[HEADER_WORDS * 8];
        logic [7:0]  t;
        logic [15:0] cs;
        int unsigned off;
        for (int i = 0; i < HEADER_WORDS * 8; i++)
            b[i] = (i < n * 8) ? held_byte(i) : 8'd0;
        for (int i = 0; i < MAC_BYTES; i++)
        begin
            t = b[i];
            b[i] = b[i + MAC_BYTES];
            b[i + MAC_BYTES] = t;
        end
        for (int i = 0; i < 4; i++)
        begin
            t = b[IP_SRC_POS + i];
            b[IP_SRC_POS + i] = b[IP_DST_POS + i];
            b[IP_DST_POS + i] = t;
        end
        t = b[TTL_POS];
        b[TTL_POS] = ttl_reg;
        cs = incr_csum({b[IP_CSUM_POS], b[IP_CSUM_POS + 1]}, {t, 8'h00}, {ttl_reg, 8'h00});
        b[IP_CSUM_POS] = cs[15:8];
        b[IP_CSUM_POS + 1] = cs[7:0];
        off = IHL_POS + 4 * b[IHL_POS][3:0];
        b[off] = ICMP_ECHO_REPLY;
        cs = incr_csum({b[off + 2], b[off + 3]}, ICMP_TYPE_OLD, ICMP_TYPE_NEW);
        b[off + 2] = cs[15:8];
        b[off + 3] = cs[7:0];
        for (int i = 0; i < n; i++)
            for (int k = 0; k < 8; k++)
                held[i][8 * (7 - k) +: 8] = b[i * 8 + k];
    endfunction

    function automatic void predict_beat(logic [63:0] w, logic [3:0] wb, logic fe);
        int unsigned lastb;
        int unsigned n;
        int unsigned avail;
        int unsigned off;
        bit          need_more;
        lastb = fe ? ((wb > 8) ? 8 : wb) : 8;
        if (decided)
        begin
            reply_beats.push_back('{w, 4'(lastb), fe, is_reply});
            if (fe)
            begin
                decided = 0;
                is_reply = 0;
                n_held = 0;
            end
            return;
        end
        held[n_held % HEADER_WORDS] = w;
        n_held++;
        n = n_held;
        avail = (n - 1) * 8 + lastb;
        need_more = 0;
        is_reply = 0;
        if (avail < MIN_IP_BYTES)
            need_more = 1;
        else if (held_byte(PROTO_POS) == PROTO_ICMP)
        begin
            off = IHL_POS + 4 * (held_byte(IHL_POS) & 8'h0f);
            if (avail < off + ICMP_HDR_BYTES)
                need_more = 1;
            else
                is_reply = (held_byte(off) == ICMP_ECHO_REQUEST);
        end
        if (need_more && !fe && n < HEADER_WORDS)
            return;
        decided = 1;
        if (is_reply)
            make_reply(n);
        for (int i = 0; i < n; i++)
            reply_beats.push_back('{held[i], (i == n - 1) ? 4'(lastb) : 4'd8,
                                    (i == n - 1) && fe, is_reply});
        if (fe)
        begin
            decided = 0;
            is_reply = 0;
        end
        n_held = 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reply_beats.delete();
            n_held = 0;
            decided = 0;
            is_reply = 0;
            ttl_reg = TTL_RESET;
            fails = 0;
        end
        else
        begin
            if (reply_ttl_we)
                ttl_reg = reply_ttl_wdata;
            if (pop && !empty)
            begin
                got = '{out_word, out_bytes, out_end, send_back};
                if (reply_beats.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected beat: word %h bytes %0d end %0b reply %0b",
                                 got.word, got.nbytes, got.last, got.reply);
                end
                else
                begin
                    want = reply_beats.pop_front();
                    if (got !== want)
                    begin
                        fails++;
                        if (fails <= 10)
                            $display({"mismatch: got word %h bytes %0d end %0b reply %0b, ",
                                      "want word %h bytes %0d end %0b reply %0b"},
                                     got.word, got.nbytes, got.last, got.reply,
                                     want.word, want.nbytes, want.last, want.reply);
                    end
                end
            end
            if (push && !full)
                predict_beat(frame_word, word_bytes, frame_end);
        end
        fail_count <= fails;
        pending <= reply_beats.size();
    end

endmodule

// ----- test/tb_icmp_echo_reply_rewriter_core.sv -----
`timescale 1ns / 1ps
module tb_icmp_echo_reply_rewriter_core;
    import icmprw_pkg::*;

    localparam int         PROTO_POS = 23;
    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam int         FRAME_MAX = 160;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [63:0] frame_word = 64'd0;
    logic [3:0]  word_bytes = 4'd8;
    logic        frame_end = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [63:0] out_word;
    logic [3:0]  out_bytes;
    logic        out_end;
    logic        send_back;
    logic        reply_ttl_we = 1'b0;
    logic [7:0]  reply_ttl_wdata = 8'd0;

    int          fail_count;
    int          pending;
    int          beats_sent = 0;
    bit          steady = 0;
    logic [7:0]  frame_bytes[FRAME_MAX];
    int          frame_len;

    icmp_echo_reply_rewriter_core DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .frame_word      (frame_word),
        .word_bytes      (word_bytes),
        .frame_end       (frame_end),
        .empty           (empty),
        .pop             (pop),
        .out_word        (out_word),
        .out_bytes       (out_bytes),
        .out_end         (out_end),
        .send_back       (send_back),
        .reply_ttl_we    (reply_ttl_we),
        .reply_ttl_wdata (reply_ttl_wdata)
    );

    icmp_echo_checker u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .frame_word      (frame_word),
        .word_bytes      (word_bytes),
        .frame_end       (frame_end),
        .empty           (empty),
        .pop             (pop),
        .out_word        (out_word),
        .out_bytes       (out_bytes),
        .out_end         (out_end),
        .send_back       (send_back),
        .reply_ttl_we    (reply_ttl_we),
        .reply_ttl_wdata (reply_ttl_wdata),
        .fail_count      (fail_count),
        .pending         (pending)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic send_beat(logic [63:0] w, logic [3:0] wb, logic fe);
        push <= 1'b1;
        frame_word <= w;
        word_bytes <= wb;
        frame_end <= fe;
        @(posedge clk);
        while (full)
            @(posedge clk);
        beats_sent++;
    endtask

    task automatic pause_send();
        int roll;
        int gap;
        roll = $urandom_range(0, 99);
        if (steady || roll < 60)
            return;
        gap = (roll < 92) ? $urandom_range(1, 3) : $urandom_range(5, 30);
        push <= 1'b0;
        repeat (gap) @(posedge clk);
    endtask

    // last_force < 0 keeps the true tail count on the final beat
    task automatic send_frame(int last_force, bit ragged);
        int          nwords;
        int          tail;
        logic [63:0] w;
        logic [3:0]  wb;
        nwords = (frame_len + 7) / 8;
        tail = frame_len - 8 * (nwords - 1);
        for (int i = 0; i < nwords; i++)
        begin
            for (int k = 0; k < 8; k++)
                w[8 * (7 - k) +: 8] = frame_bytes[8 * i + k];
            if (i == nwords - 1)
                wb = (last_force >= 0) ? 4'(last_force) : 4'(tail);
            else
                wb = (ragged && $urandom_range(0, 1)) ? 4'($urandom_range(0, 15)) : 4'd8;
            send_beat(w, wb, i == nwords - 1);
            pause_send();
        end
    endtask

    function automatic void build_request(int ihl, int extra);
        int off;
        for (int i = 0; i < FRAME_MAX; i++)
            frame_bytes[i] = 8'($urandom);
        frame_bytes[12] = 8'h08;
        frame_bytes[13] = 8'h00;
        frame_bytes[PROTO_POS] = PROTO_ICMP;
        off = IHL_POS + 4 * ihl;
        frame_bytes[off] = ICMP_ECHO_REQUEST;
        frame_bytes[IHL_POS] = {4'h4, 4'(ihl)};
        frame_len = ((off + ICMP_HDR_BYTES > MIN_IP_BYTES) ? off + ICMP_HDR_BYTES
                                                           : MIN_IP_BYTES) + extra;
    endfunction

    task automatic random_frame();
        int kind;
        int ihl;
        int off;
        int last_force;
        kind = $urandom_range(0, 99);
        ihl = ($urandom_range(0, 9) < 6) ? 5 : $urandom_range(0, 15);
        build_request(ihl, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40)
                                                       : $urandom_range(0, 8));
        if (kind >= 60 && kind < 70)
            frame_bytes[PROTO_POS] ^= 8'($urandom_range(1, 255));
        else if (kind >= 70 && kind < 78)
        begin
            off = IHL_POS + 4 * frame_bytes[IHL_POS][3:0];
            frame_bytes[off] ^= 8'($urandom_range(1, 255));
        end
        else if (kind >= 78 && kind < 88)
            frame_len = $urandom_range(1, frame_len - 1);
        else if (kind >= 88)
        begin
            for (int i = 0; i < FRAME_MAX; i++)
                frame_bytes[i] = 8'($urandom);
            frame_len = $urandom_range(1, 96);
        end
        if ($urandom_range(0, 6) == 0)
            last_force = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(9, 15);
        else
            last_force = -1;
        steady = ($urandom_range(0, 4) == 0);
        send_frame(last_force, $urandom_range(0, 3) == 0);
    endtask

    task automatic random_phase(int beats);
        int stop_at;
        stop_at = beats_sent + beats;
        while (beats_sent < stop_at)
            random_frame();
    endtask

    // sender holds off until every beat has left, then allows for frames in flight
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_ttl(logic [7:0] value);
        reply_ttl_we <= 1'b1;
        reply_ttl_wdata <= value;
        @(posedge clk);
        reply_ttl_we <= 1'b0;
    endtask

    initial
    begin
        int run;
        int roll;
        forever
        begin
            pop <= 1'b1;
            run = $urandom_range(1, 40);
            repeat (run) @(posedge clk);
            roll = $urandom_range(0, 99);
            if (roll >= 25)
            begin
                pop <= 1'b0;
                repeat ((roll < 85) ? $urandom_range(1, 3) : $urandom_range(5, 40))
                    @(posedge clk);
            end
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single short beat with an oversized byte count
        for (int i = 0; i < FRAME_MAX; i++)
            frame_bytes[i] = 8'($urandom);
        frame_len = 8;
        send_frame(15, 0);
        // plain echo request with ragged middle beats
        build_request(5, 0);
        send_frame(-1, 1);
        // header length 2 puts the type on the ttl byte
        build_request(2, 0);
        send_frame(15, 0);
        // header length 3 puts the type inside the source address
        build_request(3, 0);
        send_frame(-1, 0);
        // not icmp, and the frame ends short on an empty beat
        build_request(5, 0);
        frame_bytes[PROTO_POS] = PROTO_TCP;
        frame_len = 33;
        send_frame(0, 0);
        // icmp but not a request
        build_request(5, 6);
        frame_bytes[IHL_POS + 20] = ICMP_ECHO_REPLY;
        send_frame(-1, 0);

        drain();
        set_ttl(8'd0);
        random_phase(110);
        drain();
        set_ttl(8'd255);
        random_phase(110);
        drain();
        set_ttl(8'($urandom_range(1, 254)));
        random_phase(110);
        drain();

        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ----- icmp_echo_reply_rewriter_core.f -----
hdl/icmprw_pkg.sv
hdl/icmprw_word_queue.sv
hdl/icmprw_front.sv
hdl/icmprw_back.sv
hdl/icmp_echo_reply_rewriter_core.sv
test/icmp_echo_checker.sv
test/tb_icmp_echo_reply_rewriter_core.sv
